/* rtl/ttim_pkg.sv */
package ttim_pkg;

   // default configuration of the index width and axis count
   localparam int INDEX_BITS_DEFAULT = 24;
   localparam int MAX_AXES_DEFAULT   = 4;

   // fixed geometry
   localparam int AXES       = 4;
   localparam int SIZE_BITS  = 16;
   localparam int AXIS_BITS  = 2;
   localparam int ORDER_BITS = 8;
   localparam int WIDE_BITS  = 64;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_DIM_ZERO   = 3'd0,
      REG_DIM_ONE    = 3'd1,
      REG_DIM_TWO    = 3'd2,
      REG_DIM_THREE  = 3'd3,
      REG_AXIS_ORDER = 3'd4
   } reg_index_type;

   // reset values
   localparam logic [SIZE_BITS-1:0]  DIM_RESET   = 16'd1;
   localparam logic [ORDER_BITS-1:0] ORDER_RESET = 8'd228;

   // configuration view handed to the datapath
   typedef struct packed {
      logic [AXES-1:0][SIZE_BITS-1:0] out_size;
      logic [AXES-1:0][AXIS_BITS-1:0] perm;
      logic [AXES-1:0][WIDE_BITS-1:0] src_stride;
      logic [WIDE_BITS-1:0]           total;
      logic                           err;
   } cfg_view_type;

endpackage

/* rtl/ttim_ifs.sv */
interface ttim_req_if #(parameter int INDEX_BITS = ttim_pkg::INDEX_BITS_DEFAULT);
   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] out_index;
   modport source (output valid, output out_index, input ready);
   modport sink   (input valid, input out_index, output ready);
endinterface

interface ttim_rsp_if #(parameter int INDEX_BITS = ttim_pkg::INDEX_BITS_DEFAULT);
   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] src_index;
   logic                  in_range;
   logic                  config_error;
   modport source (output valid, output src_index, output in_range, output config_error,
                   input ready);
   modport sink   (input valid, input src_index, input in_range, input config_error,
                   output ready);
endinterface

interface ttim_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [ttim_pkg::CSR_INDEX_BITS-1:0]    index;
   logic [ttim_pkg::CSR_DATA_BITS-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/ttim_cfg.sv */
module ttim_cfg #(
   parameter int INDEX_BITS = ttim_pkg::INDEX_BITS_DEFAULT,
   parameter int MAX_AXES   = ttim_pkg::MAX_AXES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   ttim_csr_if.sink               csr_ch,
   output ttim_pkg::cfg_view_type cfg
);

   logic [ttim_pkg::AXES-1:0][ttim_pkg::SIZE_BITS-1:0] dim_ff;
   logic [ttim_pkg::ORDER_BITS-1:0]                    order_ff;
   logic [ttim_pkg::AXES-1:0][ttim_pkg::SIZE_BITS-1:0] size;
   logic [ttim_pkg::AXES-1:0][ttim_pkg::AXIS_BITS-1:0] perm;
   logic [31:0] p01_ff, p23_ff;
   logic [ttim_pkg::WIDE_BITS-1:0] total_ff, stride0_ff, stride1_ff;
   logic        dup;
   logic        err_ff;
   logic [ttim_pkg::WIDE_BITS-1:0] limit;

   assign csr_ch.ready = 1'b1;

   // register writes, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < ttim_pkg::AXES; a++) dim_ff[a] <= ttim_pkg::DIM_RESET;
         order_ff <= ttim_pkg::ORDER_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            ttim_pkg::REG_DIM_ZERO:   dim_ff[0] <= csr_ch.data;
            ttim_pkg::REG_DIM_ONE:    dim_ff[1] <= csr_ch.data;
            ttim_pkg::REG_DIM_TWO:    dim_ff[2] <= csr_ch.data;
            ttim_pkg::REG_DIM_THREE:  dim_ff[3] <= csr_ch.data;
            ttim_pkg::REG_AXIS_ORDER: order_ff  <= csr_ch.data[ttim_pkg::ORDER_BITS-1:0];
            default: ;
         endcase
      end
   end

   // leading axes beyond the supported count are size one
   always_comb begin
      for (int a = 0; a < ttim_pkg::AXES; a++) begin
         size[a] = (a < ttim_pkg::AXES - MAX_AXES) ? ttim_pkg::SIZE_BITS'(1) : dim_ff[a];
         perm[a] = order_ff[ttim_pkg::AXIS_BITS*a +: ttim_pkg::AXIS_BITS];
      end
   end

   // repeated axis in the permutation
   always_comb begin
      dup = 1'b0;
      for (int i = 0; i < ttim_pkg::AXES; i++)
         for (int j = i + 1; j < ttim_pkg::AXES; j++)
            if (perm[i] == perm[j]) dup = 1'b1;
   end

   assign limit = ttim_pkg::WIDE_BITS'(1) << INDEX_BITS;

   // derived products over three register stages
   always_ff @(posedge clock) begin
      p01_ff     <= size[0] * size[1];
      p23_ff     <= size[2] * size[3];
      total_ff   <= ttim_pkg::WIDE_BITS'(p01_ff) * ttim_pkg::WIDE_BITS'(p23_ff);
      stride1_ff <= ttim_pkg::WIDE_BITS'(p23_ff);
      stride0_ff <= ttim_pkg::WIDE_BITS'(size[1]) * ttim_pkg::WIDE_BITS'(p23_ff);
      err_ff     <= dup || (total_ff > limit);
   end

   always_comb begin
      for (int k = 0; k < ttim_pkg::AXES; k++) cfg.out_size[k] = size[perm[k]];
      cfg.perm          = perm;
      cfg.src_stride[0] = stride0_ff;
      cfg.src_stride[1] = stride1_ff;
      cfg.src_stride[2] = ttim_pkg::WIDE_BITS'(size[3]);
      cfg.src_stride[3] = ttim_pkg::WIDE_BITS'(1);
      cfg.total         = total_ff;
      cfg.err           = err_ff;
   end

endmodule

/* rtl/ttim_div.sv */
module ttim_div #(
   parameter int INDEX_BITS = ttim_pkg::INDEX_BITS_DEFAULT,
   parameter int SIDE_BITS  = ttim_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic [INDEX_BITS-1:0]          in_dividend,
   input  logic [ttim_pkg::SIZE_BITS-1:0] divisor,
   input  logic [SIDE_BITS-1:0]           in_side,
   output logic                           out_valid,
   output logic [INDEX_BITS-1:0]          out_quot,
   output logic [ttim_pkg::SIZE_BITS-1:0] out_rem,
   output logic [SIDE_BITS-1:0]           out_side
);

   // one quotient bit per stage, dividend shifts out as quotient shifts in
   logic [INDEX_BITS-1:0]                         v_ff;
   logic [INDEX_BITS-1:0][INDEX_BITS-1:0]         dvd_ff, dvd_in, src_dvd;
   logic [INDEX_BITS-1:0][ttim_pkg::SIZE_BITS-1:0] rem_ff, rem_in, src_rem;
   logic [INDEX_BITS-1:0][SIDE_BITS-1:0]          side_ff, src_side;
   logic [INDEX_BITS-1:0]                         src_v;

   always_comb begin
      src_v[0]    = in_valid;
      src_dvd[0]  = in_dividend;
      src_rem[0]  = '0;
      src_side[0] = in_side;
      for (int i = 1; i < INDEX_BITS; i++) begin
         src_v[i]    = v_ff[i-1];
         src_dvd[i]  = dvd_ff[i-1];
         src_rem[i]  = rem_ff[i-1];
         src_side[i] = side_ff[i-1];
      end
   end

   // restoring step
   always_comb begin
      logic [ttim_pkg::SIZE_BITS:0] trial;
      logic [ttim_pkg::SIZE_BITS:0] diff;
      logic                         ge;
      for (int i = 0; i < INDEX_BITS; i++) begin
         trial     = {src_rem[i], src_dvd[i][INDEX_BITS-1]};
         diff      = trial - {1'b0, divisor};
         ge        = trial >= {1'b0, divisor};
         rem_in[i] = ge ? diff[ttim_pkg::SIZE_BITS-1:0] : trial[ttim_pkg::SIZE_BITS-1:0];
         dvd_in[i] = {src_dvd[i][INDEX_BITS-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= src_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dvd_ff  <= dvd_in;
         rem_ff  <= rem_in;
         side_ff <= src_side;
      end
   end

   assign out_valid = v_ff[INDEX_BITS-1];
   assign out_quot  = dvd_ff[INDEX_BITS-1];
   assign out_rem   = rem_ff[INDEX_BITS-1];
   assign out_side  = side_ff[INDEX_BITS-1];

endmodule

/* rtl/ttim_sum.sv */
module ttim_sum #(
   parameter int INDEX_BITS = ttim_pkg::INDEX_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [INDEX_BITS-1:0]  idx,
   input  logic [ttim_pkg::AXES-1:0][ttim_pkg::SIZE_BITS-1:0] digit,
   input  ttim_pkg::cfg_view_type cfg,
   ttim_rsp_if.source             rsp_ch
);

   logic                                     v1_ff, ok1_ff, err1_ff;
   logic [ttim_pkg::AXES-1:0][INDEX_BITS-1:0] prod_ff, prod_in;
   logic                                     v2_ff, ok2_ff, err2_ff;
   logic [INDEX_BITS-1:0]                    src_ff, src_in;

   // digit times the stride of its source axis
   always_comb begin
      logic [INDEX_BITS+ttim_pkg::SIZE_BITS-1:0] full;
      for (int k = 0; k < ttim_pkg::AXES; k++) begin
         full       = digit[k] * cfg.src_stride[cfg.perm[k]][INDEX_BITS-1:0];
         prod_in[k] = full[INDEX_BITS-1:0];
      end
   end

   // recombine, flagged results give zero
   always_comb begin
      src_in = prod_ff[0] + prod_ff[1] + prod_ff[2] + prod_ff[3];
      if (!ok1_ff || err1_ff) src_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         ok1_ff  <= ttim_pkg::WIDE_BITS'(idx) < cfg.total;
         err1_ff <= cfg.err;
         src_ff  <= src_in;
         ok2_ff  <= ok1_ff;
         err2_ff <= err1_ff;
      end
   end

   assign rsp_ch.valid        = v2_ff;
   assign rsp_ch.src_index    = src_ff;
   assign rsp_ch.in_range     = ok2_ff;
   assign rsp_ch.config_error = err2_ff;

endmodule

/* rtl/tensor_transpose_index_map.sv */
// path: three dividers, then product and sum registers, from request to result
// throughput: one request per cycle when not held, one quotient bit per stage
// the whole pipeline holds when a result waits and is not taken
// reset: synchronous, clears valid bits, sizes to 1 and axis order to identity
// derived config settles via product, total and error registers after a write
module tensor_transpose_index_map #(
   parameter int INDEX_BITS = ttim_pkg::INDEX_BITS_DEFAULT,
   parameter int MAX_AXES   = ttim_pkg::MAX_AXES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   ttim_req_if.sink   req_ch,
   ttim_rsp_if.source rsp_ch,
   ttim_csr_if.sink   csr_ch
);

   localparam int SB = ttim_pkg::SIZE_BITS;

   ttim_pkg::cfg_view_type cfg;
   logic en;

   logic                       v1, v2, v3;
   logic [INDEX_BITS-1:0]      q1, q2, q3;
   logic [SB-1:0]              r1, r2, r3;
   logic [INDEX_BITS-1:0]      s1;
   logic [INDEX_BITS+SB-1:0]   s2;
   logic [INDEX_BITS+2*SB-1:0] s3;
   logic [ttim_pkg::AXES-1:0][SB-1:0] digit;

   // global hold while the result register is full and not taken
   assign en           = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = en;

   ttim_cfg #(.INDEX_BITS(INDEX_BITS), .MAX_AXES(MAX_AXES)) u_cfg (
      .clock(clock), .reset(reset), .csr_ch(csr_ch), .cfg(cfg)
   );

   // least significant output axis first
   ttim_div #(.INDEX_BITS(INDEX_BITS), .SIDE_BITS(INDEX_BITS)) u_div3 (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_ch.valid),
      .in_dividend(req_ch.out_index), .divisor(cfg.out_size[3]),
      .in_side(req_ch.out_index),
      .out_valid(v1), .out_quot(q1), .out_rem(r1), .out_side(s1)
   );

   ttim_div #(.INDEX_BITS(INDEX_BITS), .SIDE_BITS(INDEX_BITS+SB)) u_div2 (
      .clock(clock), .reset(reset), .en(en), .in_valid(v1),
      .in_dividend(q1), .divisor(cfg.out_size[2]), .in_side({s1, r1}),
      .out_valid(v2), .out_quot(q2), .out_rem(r2), .out_side(s2)
   );

   ttim_div #(.INDEX_BITS(INDEX_BITS), .SIDE_BITS(INDEX_BITS+2*SB)) u_div1 (
      .clock(clock), .reset(reset), .en(en), .in_valid(v2),
      .in_dividend(q2), .divisor(cfg.out_size[1]), .in_side({s2, r2}),
      .out_valid(v3), .out_quot(q3), .out_rem(r3), .out_side(s3)
   );

   // digits per output axis
   assign digit[0] = q3[SB-1:0];
   assign digit[1] = r3;
   assign digit[2] = s3[SB-1:0];
   assign digit[3] = s3[2*SB-1:SB];

   ttim_sum #(.INDEX_BITS(INDEX_BITS)) u_sum (
      .clock(clock), .reset(reset), .en(en), .in_valid(v3),
      .idx(s3[INDEX_BITS+2*SB-1:2*SB]), .digit(digit), .cfg(cfg), .rsp_ch(rsp_ch)
   );

endmodule

/* tb/sv/tb_tensor_transpose_index_map.sv */
module tb_tensor_transpose_index_map;

   localparam int IDX_BITS      = ttim_pkg::INDEX_BITS_DEFAULT;
   localparam int USED_AXES     = ttim_pkg::MAX_AXES_DEFAULT;
   localparam int AXES          = ttim_pkg::AXES;
   localparam int SIZE_BITS     = ttim_pkg::SIZE_BITS;
   localparam int ORDER_BITS    = ttim_pkg::ORDER_BITS;
   localparam int CSR_DATA_BITS = ttim_pkg::CSR_DATA_BITS;
   localparam int LATENCY       = 3 * IDX_BITS + 2;
   localparam int IDLE_LIMIT    = 5000;
   localparam int SETTLE_WAIT   = 4;

   typedef logic [IDX_BITS-1:0] index_type;

   typedef struct {
      index_type src_index;
      logic      in_range;
      logic      config_error;
   } lookup_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ttim_req_if #(.INDEX_BITS(IDX_BITS)) req_ch ();
   ttim_rsp_if #(.INDEX_BITS(IDX_BITS)) rsp_ch ();
   ttim_csr_if                          csr_ch ();

   tensor_transpose_index_map #(.INDEX_BITS(IDX_BITS), .MAX_AXES(USED_AXES)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // shadow configuration
   logic [SIZE_BITS-1:0]  shadow_dim [AXES];
   logic [ORDER_BITS-1:0] shadow_order;

   lookup_type pending_lookups [$];
   int         fail_count;
   int         rsp_hold_cycles;
   int         idle_cycles;

   always #5 clock = ~clock;

   // source index mapping for the current shadow configuration
   function automatic lookup_type map_to_source(index_type out_idx);
      longint unsigned size [AXES];
      longint unsigned src_stride [AXES];
      longint unsigned out_stride [AXES];
      int unsigned     perm [AXES];
      longint unsigned total, acc, rem, digit, src;
      logic [AXES-1:0] seen;
      logic            err;
      lookup_type      res;
      total = 1;
      seen  = '0;
      err   = 1'b0;
      src   = 0;
      for (int k = 0; k < AXES; k++) begin
         size[k] = (k < AXES - USED_AXES) ? 1 : shadow_dim[k];
         perm[k] = shadow_order[2*k +: 2];
         if (seen[perm[k]]) err = 1'b1;
         seen[perm[k]] = 1'b1;
         total = total * size[k];
      end
      if (total > (64'd1 << IDX_BITS)) err = 1'b1;
      acc = 1;
      for (int a = AXES - 1; a >= 0; a--) begin
         src_stride[a] = acc;
         acc = acc * size[a];
      end
      acc = 1;
      for (int a = AXES - 1; a >= 0; a--) begin
         out_stride[a] = acc;
         acc = acc * size[perm[a]];
      end
      res.in_range     = (longint'(out_idx) < total);
      res.config_error = err;
      if (res.in_range && !err) begin
         rem = out_idx;
         for (int k = 0; k < AXES; k++) begin
            digit = rem / out_stride[k];
            rem   = rem - digit * out_stride[k];
            src   = src + digit * src_stride[perm[k]];
         end
      end
      res.src_index = index_type'(src);
      return res;
   endfunction

   task automatic report_mismatch(string what);
      fail_count++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // send one request, leaving valid high for a back-to-back follower
   task automatic send_request(index_type out_idx);
      int gap;
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.out_index <= out_idx;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      pending_lookups.push_back(map_to_source(out_idx));
   endtask

   // withdraw valid straight after the last accepted request
   task automatic drop_request;
      req_ch.valid <= 1'b0;
   endtask

   task automatic drain;
      drop_request();
      while (pending_lookups.size() != 0) @(posedge clock);
   endtask

   // write all registers in one burst, then let derived values settle
   task automatic write_registers(logic [SIZE_BITS-1:0] d0, logic [SIZE_BITS-1:0] d1,
                                  logic [SIZE_BITS-1:0] d2, logic [SIZE_BITS-1:0] d3,
                                  logic [CSR_DATA_BITS-1:0] order);
      logic [CSR_DATA_BITS-1:0]    vals [5];
      ttim_pkg::reg_index_type     regs [5];
      drain();
      vals = '{d0, d1, d2, d3, order};
      regs = '{ttim_pkg::REG_DIM_ZERO, ttim_pkg::REG_DIM_ONE, ttim_pkg::REG_DIM_TWO,
               ttim_pkg::REG_DIM_THREE, ttim_pkg::REG_AXIS_ORDER};
      for (int i = 0; i < 5; i++) begin
         csr_ch.valid <= 1'b1;
         csr_ch.index <= regs[i];
         csr_ch.data  <= vals[i];
         do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
         if (regs[i] == ttim_pkg::REG_AXIS_ORDER) shadow_order = vals[i][ORDER_BITS-1:0];
         else shadow_dim[i] = vals[i];
      end
      csr_ch.valid <= 1'b0;
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   function automatic logic [ORDER_BITS-1:0] random_permutation;
      int unsigned p [AXES];
      int unsigned j, t;
      logic [ORDER_BITS-1:0] ord;
      for (int k = 0; k < AXES; k++) p[k] = k;
      for (int k = AXES - 1; k > 0; k--) begin
         j = $urandom_range(0, k);
         t = p[k]; p[k] = p[j]; p[j] = t;
      end
      for (int k = 0; k < AXES; k++) ord[2*k +: 2] = 2'(p[k]);
      return ord;
   endfunction

   function automatic longint unsigned element_count;
      longint unsigned total;
      total = 1;
      for (int k = 0; k < AXES; k++) total = total * shadow_dim[k];
      return total;
   endfunction

   // index mostly inside the tensor, sometimes anywhere
   function automatic index_type random_index;
      longint unsigned total;
      total = element_count();
      if (total != 0 && $urandom_range(0, 9) < 8) begin
         if (total > (64'd1 << IDX_BITS)) total = 64'd1 << IDX_BITS;
         return index_type'($urandom % total);
      end
      return index_type'($urandom);
   endfunction

   // ---------------- tests ----------------

   task automatic test_reset_config;
      send_request('0);
      send_request(index_type'(1));
      send_request('1);
   endtask

   task automatic test_reversed_axes;
      write_registers(2, 3, 4, 5, 8'b00_01_10_11);
      send_request('0);
      send_request(index_type'(1));
      send_request(index_type'(37));
      send_request(index_type'(119));
      send_request(index_type'(120));
      send_request('1);
   endtask

   task automatic test_repeated_axis;
      write_registers(2, 3, 4, 5, 8'b00_00_00_00);
      send_request(index_type'(5));
      send_request(index_type'(200));
   endtask

   task automatic test_count_overflow;
      write_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'b10_11_00_01);
      send_request('0);
      send_request('1);
   endtask

   task automatic test_full_index_space;
      write_registers(256, 1, 256, 256, 8'b01_00_11_10);
      send_request('0);
      send_request('1);
      send_request(index_type'(24'h800001));
   endtask

   task automatic test_zero_size;
      write_registers(3, 0, 7, 2, 8'b11_10_01_00);
      send_request('0);
      send_request(index_type'(9));
   endtask

   task automatic test_wide_axis;
      write_registers(1, 16'hFFFF, 1, 255, 8'b11_01_00_10);
      send_request('0);
      send_request(index_type'(24'hFEFF00));
      send_request(index_type'(24'hFEFF01));
   endtask

   task automatic test_random_configs;
      logic [ORDER_BITS-1:0] ord;
      for (int phase = 0; phase < 10; phase++) begin
         ord = ($urandom_range(0, 5) == 0) ? ORDER_BITS'($urandom) : random_permutation();
         write_registers(SIZE_BITS'($urandom_range(1, 24)), SIZE_BITS'($urandom_range(1, 24)),
                         SIZE_BITS'($urandom_range(1, 24)), SIZE_BITS'($urandom_range(1, 24)),
                         {8'($urandom), ord});
         repeat (40) send_request(random_index());
      end
      write_registers(SIZE_BITS'($urandom_range(1, 9)), SIZE_BITS'($urandom_range(0, 65535)),
                      SIZE_BITS'($urandom_range(1, 3)), SIZE_BITS'($urandom_range(1, 9)),
                      CSR_DATA_BITS'(random_permutation()));
      repeat (30) send_request(random_index());
   endtask

   task automatic test_output_stall;
      write_registers(7, 5, 11, 13, CSR_DATA_BITS'(random_permutation()));
      rsp_hold_cycles = 300;
      repeat (150) send_request(random_index());
   endtask

   task automatic test_pause_until_empty;
      write_registers(16, 9, 4, 31, CSR_DATA_BITS'(random_permutation()));
      repeat (20) send_request(random_index());
      drain();
      repeat (20) send_request(random_index());
   endtask

   // ---------------- result side ----------------

   initial begin
      lookup_type exp_res;
      int         n;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         n = $urandom_range(0, 5);
         if ($urandom_range(0, 3) == 0) n = 0;
         if (rsp_hold_cycles > 0) begin
            n = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (n > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         if (pending_lookups.size() == 0) begin
            report_mismatch("result with no request outstanding");
         end else begin
            exp_res = pending_lookups.pop_front();
            if (rsp_ch.src_index !== exp_res.src_index)
               report_mismatch($sformatf("src_index %0h, want %0h",
                                         rsp_ch.src_index, exp_res.src_index));
            if (rsp_ch.in_range !== exp_res.in_range)
               report_mismatch($sformatf("in_range %0b, want %0b",
                                         rsp_ch.in_range, exp_res.in_range));
            if (rsp_ch.config_error !== exp_res.config_error)
               report_mismatch($sformatf("config_error %0b, want %0b",
                                         rsp_ch.config_error, exp_res.config_error));
         end
      end
   end

   // watchdog on cycles with no handshake anywhere
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------- sequence ----------------

   initial begin
      fail_count      = 0;
      rsp_hold_cycles = 0;
      idle_cycles     = 0;
      for (int k = 0; k < AXES; k++) shadow_dim[k] = ttim_pkg::DIM_RESET;
      shadow_order     = ttim_pkg::ORDER_RESET;
      req_ch.valid     <= 1'b0;
      req_ch.out_index <= '0;
      csr_ch.valid     <= 1'b0;
      csr_ch.index     <= ttim_pkg::REG_DIM_ZERO;
      csr_ch.data      <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_config();
      test_reversed_axes();
      test_repeated_axis();
      test_count_overflow();
      test_full_index_space();
      test_zero_size();
      test_wide_axis();
      test_random_configs();
      test_output_stall();
      test_pause_until_empty();

      drain();
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0 && pending_lookups.size() == 0) begin
         $display("simulation ok");
      end else begin
         if (pending_lookups.size() != 0) report_mismatch("results never arrived");
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/ttim_pkg.sv
rtl/ttim_ifs.sv
rtl/ttim_cfg.sv
rtl/ttim_div.sv
rtl/ttim_sum.sv
rtl/tensor_transpose_index_map.sv
tb/sv/tb_tensor_transpose_index_map.sv
